// ----- src/binary_to_decimal_ascii_core_macros.svh -----
// Assertion macros shared by the decimal text converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B2D_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2d: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define B2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2d: next-cycle check failed");

`endif

// ----- src/b2d_pkg.sv -----
// Constants shared by the decimal text converter.
package b2d_pkg;

    localparam int CHAR_W          = 6;
    localparam int DIGIT_W         = 4;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [CHAR_W-1:0]  CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  CH_MINUS = 6'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

endpackage

// ----- src/b2d_if.sv -----
// Valid/ready channel interfaces for integer words in and character words out.
interface b2d_value_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_char_if
    import b2d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/b2d_stage.sv -----
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
module b2d_stage
    import b2d_pkg::*;
#(
    parameter int NUM_DIGITS = 10,
    parameter int BIN_W      = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_neg,
    input  logic [NUM_DIGITS*DIGIT_W-1:0] in_bcd,
    input  logic [BIN_W-1:0]              in_bin,
    output logic                          out_valid,
    output logic                          out_neg,
    output logic [NUM_DIGITS*DIGIT_W-1:0] out_bcd,
    output logic [BIN_W-1:0]              out_bin
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;

    logic             valid_reg;
    logic             neg_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BIN_W-1:0] bin_next;

    // Adjust digits and shift in the next binary bit, several steps per stage
    always_comb
    begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_next[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN)
                begin
                    bcd_next[d*DIGIT_W +: DIGIT_W] =
                        bcd_next[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
                end
            end
            {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= in_neg;
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;

endmodule

// ----- src/b2d_serializer.sv -----
// Emits the minus sign and decimal digits of a converted word, one character per cycle unless the output stalls.
`include "binary_to_decimal_ascii_core_macros.svh"

module b2d_serializer
    import b2d_pkg::*;
#(
    parameter int NUM_DIGITS = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_neg,
    input  logic [NUM_DIGITS*DIGIT_W-1:0] in_bcd,
    b2d_char_if.source                    out_ch
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic               busy_reg;
    logic               minus_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic               take;
    logic               emit;
    logic               fin;
    logic               load;
    logic [IDX_W-1:0]   hi;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  char_next;
    logic               last_next;

    // Find the most significant nonzero digit; all zero keeps digit 0
    always_comb
    begin
        hi = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (in_bcd[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                hi = IDX_W'(d);
            end
        end
    end

    // Pick the next character: minus sign first, then digits downward
    always_comb
    begin
        digit = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];
        if (minus_reg)
        begin
            char_next = CH_MINUS;
            last_next = 1'b0;
        end
        else
        begin
            char_next = CH_ZERO + CHAR_W'(digit);
            last_next = (idx_reg == '0);
        end
    end

    assign take     = !out_valid_reg || out_ch.ready;
    assign emit     = busy_reg && take;
    assign fin      = emit && last_next;
    assign in_ready = !busy_reg || fin;
    assign load     = in_valid && in_ready;

    // Track the word being emitted and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end

            // A new word replaces the one that just sent its final character
            if (load)
            begin
                busy_reg  <= 1'b1;
                minus_reg <= in_neg;
                idx_reg   <= hi;
            end
            else
            begin
                if (fin)
                begin
                    busy_reg <= 1'b0;
                end
                if (emit)
                begin
                    if (minus_reg)
                    begin
                        minus_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - IDX_W'(1);
                    end
                end
            end
        end
    end

    // Hold digits and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_bcd;
        end
        if (emit)
        begin
            out_char_reg <= char_next;
            out_last_reg <= last_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.character = out_char_reg;
    assign out_ch.last      = out_last_reg;

    `B2D_ASSERT_NEXT(a_minus_first, emit && minus_reg,
        out_valid_reg && out_char_reg == CH_MINUS && !out_last_reg)
    `B2D_ASSERT_SAME(a_last_is_digit, out_valid_reg && out_last_reg,
        out_char_reg != CH_MINUS)
    `B2D_ASSERT_NEXT(a_load_busy, load, busy_reg)

endmodule

// ----- src/binary_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII text converter, top level.
//
// Usage: in_ch takes one signed VALUE_WIDTH-bit integer per word. out_ch
// returns its decimal text, one ASCII character per word, most significant
// first: a leading '-' for negative values, no leading zeros, a single '0'
// for zero, and last set on the final character. No terminator is sent.
// The conversion runs in a shift-and-add-3 pipeline: one sign/magnitude
// stage, then ceil(VALUE_WIDTH/4) stages of four steps each (8 at the
// default width), then a character serializer with an output register.
// Throughput: one character per cycle while out_ch is ready, and a word
// has 1 to 11 characters at the default width. The pipeline keeps taking
// words while earlier ones are being emitted.
// Reset clears all valid bits and the serializer; nothing else is needed.
// When out_ch stalls, the output register holds its character and the
// serializer holds. Once a converted word waits at the last stage, the
// whole pipeline holds, bubbles included, and in_ch.ready drops.
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core
    import b2d_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    b2d_value_if.sink in_ch,
    b2d_char_if.source out_ch
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int NUM_STAGES = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int PAD_W      = NUM_STAGES * STEPS_PER_STAGE;

    logic                   en;
    logic                   ser_ready;
    logic                   s0_valid_reg;
    logic                   s0_neg_reg;
    logic [PAD_W-1:0]       s0_bin_reg;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag;

    logic [NUM_STAGES:0]    vld;
    logic [NUM_STAGES:0]    negv;
    logic [BCD_W-1:0]       bcdv [NUM_STAGES+1];
    logic [PAD_W-1:0]       binv [NUM_STAGES+1];

    // Advance the whole pipeline unless its last word is blocked
    assign en          = !vld[NUM_STAGES] || ser_ready;
    assign in_ch.ready = en;

    // Form the magnitude; the most negative value fits unsigned
    assign neg_in = in_ch.value[VALUE_WIDTH-1];
    assign mag    = neg_in ? (~in_ch.value + VALUE_WIDTH'(1)) : in_ch.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg <= neg_in;
            s0_bin_reg <= PAD_W'(mag);
        end
    end

    assign vld[0]  = s0_valid_reg;
    assign negv[0] = s0_neg_reg;
    assign bcdv[0] = '0;
    assign binv[0] = s0_bin_reg;

    // Conversion stages
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        b2d_stage #(
            .NUM_DIGITS (NUM_DIGITS),
            .BIN_W      (PAD_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[g]),
            .in_neg    (negv[g]),
            .in_bcd    (bcdv[g]),
            .in_bin    (binv[g]),
            .out_valid (vld[g+1]),
            .out_neg   (negv[g+1]),
            .out_bcd   (bcdv[g+1]),
            .out_bin   (binv[g+1])
        );
    end

    // Character output
    b2d_serializer #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld[NUM_STAGES]),
        .in_ready (ser_ready),
        .in_neg   (negv[NUM_STAGES]),
        .in_bcd   (bcdv[NUM_STAGES]),
        .out_ch   (out_ch)
    );

    `B2D_ASSERT_NEXT(a_stage_advance, en && vld[0], vld[1])
    `B2D_ASSERT_NEXT(a_stall_holds, !en, $stable(vld))

endmodule
